FILE: sv/dbqg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbqg_pkg
// Types, codes and constants shared by the deny burst quarantine guard.
// ----------------------------------------------------------------------------
package dbqg_pkg;

   localparam int TIME_W  = 32;
   localparam int COUNT_W = 16;
   localparam int IDX_W   = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int DENY_W     = 64;

   localparam logic [COUNT_W-1:0] DEFAULT_WINDOW   = 16'd60;
   localparam logic [COUNT_W-1:0] DEFAULT_DURATION = 16'd300;
   localparam logic [COUNT_W-1:0] COUNT_MAX        = 16'hFFFF;

   localparam logic                 RESET_GUARD_ENABLED    = 1'b1;
   localparam logic [COUNT_W-1:0]   RESET_WINDOW_SECONDS   = 16'd60;
   localparam logic [COUNT_W-1:0]   RESET_DENY_THRESHOLD   = 16'd20;
   localparam logic [COUNT_W-1:0]   RESET_QUAR_SECONDS     = 16'd300;
   localparam logic [COUNT_W-1:0]   RESET_LOCK_THRESHOLD   = 16'd0;
   localparam logic [COUNT_W-1:0]   RESET_LOCK_SECONDS     = 16'd300;
   localparam logic [DENY_W-1:0]    RESET_DENYLIST         = 64'd0;

   typedef enum logic {
      REQ_CHECK  = 1'b0,
      REQ_RECORD = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      OUTCOME_ALLOW = 2'd0,
      OUTCOME_DENY  = 2'd1,
      OUTCOME_ERROR = 2'd2,
      OUTCOME_OTHER = 2'd3
   } outcome_type;

   typedef enum logic [1:0] {
      REASON_ORDINARY    = 2'd0,
      REASON_QUARANTINED = 2'd1,
      REASON_LOCKDOWN    = 2'd2,
      REASON_DENYLIST    = 2'd3
   } reason_type;

   typedef enum logic [1:0] {
      VERDICT_ALLOW      = 2'd0,
      VERDICT_FORBIDDEN  = 2'd1,
      VERDICT_LOCKDOWN   = 2'd2,
      VERDICT_QUARANTINE = 2'd3
   } verdict_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GUARD_ENABLED      = 3'd0,
      CSR_WINDOW_SECONDS     = 3'd1,
      CSR_DENY_THRESHOLD     = 3'd2,
      CSR_QUARANTINE_SECONDS = 3'd3,
      CSR_LOCKDOWN_THRESHOLD = 3'd4,
      CSR_LOCKDOWN_SECONDS   = 3'd5,
      CSR_DENYLIST_BITS      = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic               req_type;
      logic [IDX_W-1:0]   subject_index;
      logic               id_present;
      logic [1:0]         outcome;
      logic [1:0]         reason_class;
      logic [TIME_W-1:0]  now_seconds;
   } req_payload_type;

   typedef struct packed {
      logic req_load;
      logic mem_read;
      logic exec;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

FILE: sv/dbqg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbqg_if
// Valid/ready channels of the guard: requests, responses and CSR writes.
// ----------------------------------------------------------------------------
interface dbqg_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [5:0]  subject_index;
   logic        id_present;
   logic [1:0]  outcome;
   logic [1:0]  reason_class;
   logic [31:0] now_seconds;

   modport source (output valid, req_type, subject_index, id_present, outcome,
                   reason_class, now_seconds, input ready);
   modport sink   (input valid, req_type, subject_index, id_present, outcome,
                   reason_class, now_seconds, output ready);
endinterface

interface dbqg_rsp_if;
   logic        valid;
   logic        ready;
   logic        allowed;
   logic [1:0]  verdict;
   logic [15:0] retry_secs;
   logic        quarantine_started;
   logic        lockdown_started;

   modport source (output valid, allowed, verdict, retry_secs,
                   quarantine_started, lockdown_started, input ready);
   modport sink   (input valid, allowed, verdict, retry_secs,
                   quarantine_started, lockdown_started, output ready);
endinterface

interface dbqg_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/dbqg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbqg_ctrl
// Sequencer: accepts a request, reads its slot, then commits the update.
// ----------------------------------------------------------------------------
module dbqg_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  dbqg_pkg::dp_status_type status,
   output dbqg_pkg::ctrl_cmd_type  cmd
);

   dbqg_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dbqg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dbqg_pkg::ST_IDLE: begin
            if (req_valid) state_in = dbqg_pkg::ST_READ;
         end
         dbqg_pkg::ST_READ: begin
            state_in = dbqg_pkg::ST_EXEC;
         end
         dbqg_pkg::ST_EXEC: begin
            // A held response stalls the commit; the next request can enter
            // in the same cycle as the commit.
            if (status.out_free) begin
               state_in = req_valid ? dbqg_pkg::ST_READ : dbqg_pkg::ST_IDLE;
            end
         end
         default: state_in = dbqg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.mem_read = 1'b0;
      cmd.exec     = 1'b0;
      unique case (state_ff)
         dbqg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         dbqg_pkg::ST_READ: begin
            cmd.mem_read = 1'b1;
         end
         dbqg_pkg::ST_EXEC: begin
            req_ready = status.out_free;
            cmd.exec  = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      cmd.req_load = req_ready & req_valid;
   end

endmodule

FILE: sv/dbqg_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbqg_dp
// Datapath: CSRs, slot table memory, global burst state and response register.
// ----------------------------------------------------------------------------
module dbqg_dp #(
   parameter int SUBJECT_SLOTS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dbqg_pkg::ctrl_cmd_type              cmd,
   output dbqg_pkg::dp_status_type             status,
   input  dbqg_pkg::req_payload_type           req_payload,
   input  logic                                csr_we,
   input  logic [dbqg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dbqg_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_allowed,
   output logic [1:0]                          rsp_verdict,
   output logic [dbqg_pkg::COUNT_W-1:0]        rsp_retry,
   output logic                                rsp_quarantine_started,
   output logic                                rsp_lockdown_started
);

   localparam int ADDR_W = (SUBJECT_SLOTS > 1) ? $clog2(SUBJECT_SLOTS) : 1;
   localparam int TW = dbqg_pkg::TIME_W;
   localparam int CW = dbqg_pkg::COUNT_W;

   typedef struct packed {
      logic [TW-1:0] window_start;
      logic [CW-1:0] burst_count;
      logic [TW-1:0] quarantine_end;
      logic          quarantine_valid;
   } slot_entry_type;

   typedef struct packed {
      logic [TW-1:0] start;
      logic [CW-1:0] count;
      logic          trig;
   } bump_type;

   function automatic bump_type bump(input logic [TW-1:0] start,
                                     input logic [CW-1:0] count,
                                     input logic [TW-1:0] now,
                                     input logic [CW-1:0] win,
                                     input logic [CW-1:0] thr);
      bump_type      r;
      logic [TW-1:0] elapsed;
      r.start = start;
      r.count = count;
      r.trig  = 1'b0;
      elapsed = now - start;
      if (thr != '0) begin
         if (count == '0 || elapsed >= {{(TW-CW){1'b0}}, win}) begin
            r.start = now;
            r.count = CW'(1);
         end else begin
            if (count != dbqg_pkg::COUNT_MAX) r.count = count + CW'(1);
            r.trig = (r.count >= thr);
         end
      end
      return r;
   endfunction

   function automatic logic [TW-1:0] deadline_after(input logic [TW-1:0] now,
                                                    input logic [CW-1:0] dur);
      logic [TW:0] sum;
      sum = {1'b0, now} + {{(TW+1-CW){1'b0}}, dur};
      return sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
   endfunction

   function automatic logic [CW-1:0] retry_from(input logic [TW-1:0] end_time,
                                                input logic [TW-1:0] now);
      logic [TW-1:0] d;
      d = end_time - now;
      return (d[TW-1:CW] != '0) ? dbqg_pkg::COUNT_MAX : d[CW-1:0];
   endfunction

   // Configuration registers.
   logic                         guard_enabled_ff;
   logic [CW-1:0]                window_seconds_ff;
   logic [CW-1:0]                deny_threshold_ff;
   logic [CW-1:0]                quarantine_seconds_ff;
   logic [CW-1:0]                lockdown_threshold_ff;
   logic [CW-1:0]                lockdown_seconds_ff;
   logic [dbqg_pkg::DENY_W-1:0]  denylist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         guard_enabled_ff      <= dbqg_pkg::RESET_GUARD_ENABLED;
         window_seconds_ff     <= dbqg_pkg::RESET_WINDOW_SECONDS;
         deny_threshold_ff     <= dbqg_pkg::RESET_DENY_THRESHOLD;
         quarantine_seconds_ff <= dbqg_pkg::RESET_QUAR_SECONDS;
         lockdown_threshold_ff <= dbqg_pkg::RESET_LOCK_THRESHOLD;
         lockdown_seconds_ff   <= dbqg_pkg::RESET_LOCK_SECONDS;
         denylist_ff           <= dbqg_pkg::RESET_DENYLIST;
      end else if (csr_we) begin
         unique case (csr_index)
            dbqg_pkg::CSR_GUARD_ENABLED:      guard_enabled_ff      <= csr_data[0];
            dbqg_pkg::CSR_WINDOW_SECONDS:     window_seconds_ff     <= csr_data[CW-1:0];
            dbqg_pkg::CSR_DENY_THRESHOLD:     deny_threshold_ff     <= csr_data[CW-1:0];
            dbqg_pkg::CSR_QUARANTINE_SECONDS: quarantine_seconds_ff <= csr_data[CW-1:0];
            dbqg_pkg::CSR_LOCKDOWN_THRESHOLD: lockdown_threshold_ff <= csr_data[CW-1:0];
            dbqg_pkg::CSR_LOCKDOWN_SECONDS:   lockdown_seconds_ff   <= csr_data[CW-1:0];
            dbqg_pkg::CSR_DENYLIST_BITS:      denylist_ff           <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Request register.
   dbqg_pkg::req_payload_type req_ff;

   always_ff @(posedge clock) begin
      if (cmd.req_load) req_ff <= req_payload;
   end

   logic [ADDR_W-1:0] addr;
   logic              in_table;

   assign addr     = req_ff.subject_index[ADDR_W-1:0];
   assign in_table = ({1'b0, req_ff.subject_index} <
                      (dbqg_pkg::IDX_W+1)'(SUBJECT_SLOTS));

   // Slot table. Entries that were never written since reset read as zero
   // through the per-slot valid flops.
   slot_entry_type             slot_mem [SUBJECT_SLOTS];
   slot_entry_type             rd_data_ff;
   logic                       slot_hit_ff;
   logic [SUBJECT_SLOTS-1:0]   slot_valid_ff;
   logic                       mem_we;
   slot_entry_type             wr_entry;

   always_ff @(posedge clock) begin
      if (cmd.mem_read) rd_data_ff <= slot_mem[addr];
      if (mem_we) slot_mem[addr] <= wr_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         slot_hit_ff   <= 1'b0;
      end else begin
         if (cmd.mem_read) slot_hit_ff <= in_table && slot_valid_ff[addr];
         if (mem_we) slot_valid_ff[addr] <= 1'b1;
      end
   end

   // Global burst and lockdown state.
   logic [TW-1:0] global_start_ff, global_start_in;
   logic [CW-1:0] global_count_ff, global_count_in;
   logic [TW-1:0] lockdown_end_ff, lockdown_end_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         global_start_ff <= '0;
         global_count_ff <= '0;
         lockdown_end_ff <= '0;
      end else begin
         global_start_ff <= global_start_in;
         global_count_ff <= global_count_in;
         lockdown_end_ff <= lockdown_end_in;
      end
   end

   // Update logic.
   slot_entry_type        entry;
   logic [TW-1:0]         now;
   logic [CW-1:0]         win;
   logic [CW-1:0]         quar_dur;
   logic [CW-1:0]         lock_dur;
   logic                  counted;
   logic                  lock_active;
   bump_type              slot_b;
   bump_type              glob_b;
   logic                  allowed_in;
   dbqg_pkg::verdict_type verdict_in;
   logic [CW-1:0]         retry_in;
   logic                  qs_in;
   logic                  ls_in;

   assign entry    = slot_hit_ff ? rd_data_ff : '0;
   assign now      = req_ff.now_seconds;
   assign win      = (window_seconds_ff == '0) ? dbqg_pkg::DEFAULT_WINDOW
                                                : window_seconds_ff;
   assign quar_dur = (quarantine_seconds_ff == '0) ? dbqg_pkg::DEFAULT_DURATION
                                                    : quarantine_seconds_ff;
   assign lock_dur = (lockdown_seconds_ff == '0) ? dbqg_pkg::DEFAULT_DURATION
                                                  : lockdown_seconds_ff;
   assign counted  = guard_enabled_ff && req_ff.id_present &&
                     (req_ff.reason_class == dbqg_pkg::REASON_ORDINARY) &&
                     ((req_ff.outcome == dbqg_pkg::OUTCOME_DENY) ||
                      (req_ff.outcome == dbqg_pkg::OUTCOME_ERROR));
   assign lock_active = (lockdown_end_ff > now);
   assign slot_b = bump(entry.window_start, entry.burst_count, now, win,
                        deny_threshold_ff);
   assign glob_b = bump(global_start_ff, global_count_ff, now, win,
                        lockdown_threshold_ff);

   always_comb begin
      allowed_in      = 1'b1;
      verdict_in      = dbqg_pkg::VERDICT_ALLOW;
      retry_in        = '0;
      qs_in           = 1'b0;
      ls_in           = 1'b0;
      wr_entry        = entry;
      mem_we          = 1'b0;
      global_start_in = global_start_ff;
      global_count_in = global_count_ff;
      lockdown_end_in = lockdown_end_ff;
      if (cmd.exec) begin
         if (req_ff.req_type == dbqg_pkg::REQ_CHECK) begin
            if (!guard_enabled_ff) begin
               allowed_in = 1'b1;
            end else if (denylist_ff[req_ff.subject_index]) begin
               allowed_in = 1'b0;
               verdict_in = dbqg_pkg::VERDICT_FORBIDDEN;
            end else if (lock_active) begin
               allowed_in = 1'b0;
               verdict_in = dbqg_pkg::VERDICT_LOCKDOWN;
               retry_in   = retry_from(lockdown_end_ff, now);
            end else if (in_table && entry.quarantine_valid) begin
               if (entry.quarantine_end <= now) begin
                  // Expired quarantine is dropped on the check that sees it.
                  wr_entry.quarantine_valid = 1'b0;
                  mem_we = 1'b1;
               end else begin
                  allowed_in = 1'b0;
                  verdict_in = dbqg_pkg::VERDICT_QUARANTINE;
                  retry_in   = retry_from(entry.quarantine_end, now);
               end
            end
         end else if (counted) begin
            if (in_table) begin
               mem_we = 1'b1;
               wr_entry.window_start = slot_b.start;
               wr_entry.burst_count  = slot_b.count;
               if (slot_b.trig) begin
                  wr_entry.quarantine_end   = deadline_after(now, quar_dur);
                  wr_entry.quarantine_valid = 1'b1;
                  qs_in = 1'b1;
               end
            end
            global_start_in = glob_b.start;
            global_count_in = glob_b.count;
            if (glob_b.trig) begin
               lockdown_end_in = deadline_after(now, lock_dur);
               ls_in = 1'b1;
            end
         end
      end
   end

   // Response register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_allowed_ff;
   dbqg_pkg::verdict_type rsp_verdict_ff;
   logic [CW-1:0]         rsp_retry_ff;
   logic                  rsp_qs_ff;
   logic                  rsp_ls_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_allowed_ff <= allowed_in;
         rsp_verdict_ff <= verdict_in;
         rsp_retry_ff   <= retry_in;
         rsp_qs_ff      <= qs_in;
         rsp_ls_ff      <= ls_in;
      end
   end

   assign status.out_free        = !rsp_valid_ff || rsp_ready;
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_allowed            = rsp_allowed_ff;
   assign rsp_verdict            = rsp_verdict_ff;
   assign rsp_retry              = rsp_retry_ff;
   assign rsp_quarantine_started = rsp_qs_ff;
   assign rsp_lockdown_started   = rsp_ls_ff;

endmodule

FILE: sv/deny_burst_quarantine_guard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deny_burst_quarantine_guard
// Access guard with per-subject deny-burst quarantine and global lockdown.
// ----------------------------------------------------------------------------
// A request passes through ST_READ, which reads the subject's slot from the
// table memory, and then ST_EXEC, which computes the verdict, writes the slot
// back and loads the response register. The next request is accepted during
// ST_EXEC, so a new request enters only as the last one commits. While a
// response is not taken, the commit waits and holds off the next request.
// Reset needs no clearing pass: each slot has a valid flop that reset clears,
// and a slot not yet written reads as all zero. CSR writes are always taken
// and belong only to idle periods.
module deny_burst_quarantine_guard #(
   parameter int SUBJECT_SLOTS = 64
) (
   input  logic      clock,
   input  logic      reset,
   dbqg_req_if.sink  req_ch,
   dbqg_rsp_if.source rsp_ch,
   dbqg_csr_if.sink  csr_ch
);

   dbqg_pkg::ctrl_cmd_type    cmd;
   dbqg_pkg::dp_status_type   status;
   dbqg_pkg::req_payload_type req_payload;
   logic                      req_ready;

   assign req_payload.req_type      = req_ch.req_type;
   assign req_payload.subject_index = req_ch.subject_index;
   assign req_payload.id_present    = req_ch.id_present;
   assign req_payload.outcome       = req_ch.outcome;
   assign req_payload.reason_class  = req_ch.reason_class;
   assign req_payload.now_seconds   = req_ch.now_seconds;
   assign req_ch.ready              = req_ready;
   assign csr_ch.ready              = 1'b1;

   dbqg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dbqg_dp #(
      .SUBJECT_SLOTS (SUBJECT_SLOTS)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .req_payload            (req_payload),
      .csr_we                 (csr_ch.valid),
      .csr_index              (csr_ch.index),
      .csr_data               (csr_ch.data),
      .rsp_valid              (rsp_ch.valid),
      .rsp_ready              (rsp_ch.ready),
      .rsp_allowed            (rsp_ch.allowed),
      .rsp_verdict            (rsp_ch.verdict),
      .rsp_retry              (rsp_ch.retry_secs),
      .rsp_quarantine_started (rsp_ch.quarantine_started),
      .rsp_lockdown_started   (rsp_ch.lockdown_started)
   );

   // A request always passes through the slot read before the next enters.
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request accepted during slot read");

   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.allowed == (rsp_ch.verdict == dbqg_pkg::VERDICT_ALLOW)))
      else $error("allowed flag disagrees with verdict");

   // Retry time is nonzero exactly for lockdown and quarantine verdicts.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ((rsp_ch.retry_secs != '0) ==
                        ((rsp_ch.verdict == dbqg_pkg::VERDICT_LOCKDOWN) ||
                         (rsp_ch.verdict == dbqg_pkg::VERDICT_QUARANTINE))))
      else $error("retry time inconsistent with verdict");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.quarantine_started || rsp_ch.lockdown_started))
      |-> (rsp_ch.allowed && (rsp_ch.verdict == dbqg_pkg::VERDICT_ALLOW)))
      else $error("start flag on a check response");

endmodule

FILE: verif/deny_burst_quarantine_guard_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deny_burst_quarantine_guard_test
// Self-checking bench for the deny burst quarantine guard. A scripted table
// covers field extremes, ignored outcomes, verdict precedence and deadline
// saturation. Randomized phases then push burst sequences through several
// register settings. Every response is checked against the script's expected
// values or a predictor in this bench.
// ----------------------------------------------------------------------------
module deny_burst_quarantine_guard_test;

   localparam int SLOTS         = 64;
   localparam int HOLD_CYCLES   = 400;
   localparam int STALL_LIMIT   = 5000;
   localparam int RANDOM_ITEMS  = 1350;
   localparam int PHASES        = 9;
   localparam int SETTLE_CYCLES = 20;
   localparam logic [dbqg_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;

   typedef struct packed {
      logic                         allowed;
      dbqg_pkg::verdict_type        verdict;
      logic [dbqg_pkg::COUNT_W-1:0] retry;
      logic                         quarantine_started;
      logic                         lockdown_started;
   } verdict_rec_type;

   typedef enum logic {
      STEP_REQUEST,
      STEP_CSR
   } step_kind_type;

   typedef struct {
      step_kind_type                   kind;
      logic [dbqg_pkg::CSR_IDX_W-1:0]  csr_index;
      logic [dbqg_pkg::CSR_DATA_W-1:0] csr_value;
      dbqg_pkg::req_payload_type       req;
      bit                              typed;
      verdict_rec_type                 want;
   } script_step_type;

   localparam verdict_rec_type PASS_RESULT =
      '{1'b1, dbqg_pkg::VERDICT_ALLOW, 16'd0, 1'b0, 1'b0};

   logic clock;
   logic reset;

   dbqg_req_if req_ch ();
   dbqg_rsp_if rsp_ch ();
   dbqg_csr_if csr_ch ();

   deny_burst_quarantine_guard #(.SUBJECT_SLOTS(SLOTS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Predicted register file and slot table.
   logic                          cfg_enabled  = dbqg_pkg::RESET_GUARD_ENABLED;
   logic [dbqg_pkg::COUNT_W-1:0]  cfg_window   = dbqg_pkg::RESET_WINDOW_SECONDS;
   logic [dbqg_pkg::COUNT_W-1:0]  cfg_deny_thr = dbqg_pkg::RESET_DENY_THRESHOLD;
   logic [dbqg_pkg::COUNT_W-1:0]  cfg_quar_sec = dbqg_pkg::RESET_QUAR_SECONDS;
   logic [dbqg_pkg::COUNT_W-1:0]  cfg_lock_thr = dbqg_pkg::RESET_LOCK_THRESHOLD;
   logic [dbqg_pkg::COUNT_W-1:0]  cfg_lock_sec = dbqg_pkg::RESET_LOCK_SECONDS;
   logic [dbqg_pkg::DENY_W-1:0]   cfg_denylist = dbqg_pkg::RESET_DENYLIST;

   logic [dbqg_pkg::TIME_W-1:0]   slot_start [SLOTS] = '{default: '0};
   logic [dbqg_pkg::COUNT_W-1:0]  slot_count [SLOTS] = '{default: '0};
   logic [dbqg_pkg::TIME_W-1:0]   slot_qend  [SLOTS] = '{default: '0};
   bit                            slot_qvalid[SLOTS] = '{default: 1'b0};
   logic [dbqg_pkg::TIME_W-1:0]   glob_start = '0;
   logic [dbqg_pkg::COUNT_W-1:0]  glob_count = '0;
   logic [dbqg_pkg::TIME_W-1:0]   lockdown_until = '0;

   verdict_rec_type pending_verdicts[$];
   script_step_type script[$];
   int              mismatch_count = 0;
   int              stall_cycles = 0;
   bit              steady = 1'b0;
   bit              hold_rsp = 1'b0;

   function automatic bit bump_burst(inout logic [dbqg_pkg::TIME_W-1:0] start,
                                     inout logic [dbqg_pkg::COUNT_W-1:0] count,
                                     input logic [dbqg_pkg::TIME_W-1:0] now,
                                     input logic [dbqg_pkg::COUNT_W-1:0] win,
                                     input logic [dbqg_pkg::COUNT_W-1:0] thr);
      logic [dbqg_pkg::TIME_W-1:0] elapsed;
      elapsed = now - start;
      if (thr == 0) return 1'b0;
      if (count == 0 || elapsed >= {16'd0, win}) begin
         start = now;
         count = 16'd1;
         return 1'b0;
      end
      if (count != dbqg_pkg::COUNT_MAX) count = count + 16'd1;
      return count >= thr;
   endfunction

   function automatic logic [dbqg_pkg::TIME_W-1:0] deadline_at(
         logic [dbqg_pkg::TIME_W-1:0] now, logic [dbqg_pkg::COUNT_W-1:0] dur);
      logic [dbqg_pkg::TIME_W:0] sum;
      sum = {1'b0, now} + {17'd0, dur};
      return sum[dbqg_pkg::TIME_W] ? '1 : sum[dbqg_pkg::TIME_W-1:0];
   endfunction

   function automatic logic [dbqg_pkg::COUNT_W-1:0] retry_span(
         logic [dbqg_pkg::TIME_W-1:0] until_t, logic [dbqg_pkg::TIME_W-1:0] now);
      logic [dbqg_pkg::TIME_W-1:0] d;
      d = until_t - now;
      return (d > 32'h0000_FFFF) ? dbqg_pkg::COUNT_MAX : d[dbqg_pkg::COUNT_W-1:0];
   endfunction

   // Computes the response to one request and advances the predicted state.
   function automatic verdict_rec_type guard_verdict(dbqg_pkg::req_payload_type p);
      verdict_rec_type              r;
      logic [dbqg_pkg::COUNT_W-1:0] win;
      logic [dbqg_pkg::COUNT_W-1:0] dur;
      int                           s;
      r = PASS_RESULT;
      s = p.subject_index;
      if (p.req_type == dbqg_pkg::REQ_CHECK) begin
         if (!cfg_enabled) begin
            // A disabled guard lets every check through.
         end else if (cfg_denylist[s]) begin
            r.allowed = 1'b0;
            r.verdict = dbqg_pkg::VERDICT_FORBIDDEN;
         end else if (lockdown_until > p.now_seconds) begin
            r.allowed = 1'b0;
            r.verdict = dbqg_pkg::VERDICT_LOCKDOWN;
            r.retry   = retry_span(lockdown_until, p.now_seconds);
         end else if (slot_qvalid[s]) begin
            if (slot_qend[s] <= p.now_seconds) begin
               slot_qvalid[s] = 1'b0;
            end else begin
               r.allowed = 1'b0;
               r.verdict = dbqg_pkg::VERDICT_QUARANTINE;
               r.retry   = retry_span(slot_qend[s], p.now_seconds);
            end
         end
      end else if (cfg_enabled && p.id_present &&
                   p.reason_class == dbqg_pkg::REASON_ORDINARY &&
                   (p.outcome == dbqg_pkg::OUTCOME_DENY ||
                    p.outcome == dbqg_pkg::OUTCOME_ERROR)) begin
         win = (cfg_window != 0) ? cfg_window : dbqg_pkg::DEFAULT_WINDOW;
         if (bump_burst(slot_start[s], slot_count[s], p.now_seconds, win,
                        cfg_deny_thr)) begin
            dur = (cfg_quar_sec != 0) ? cfg_quar_sec : dbqg_pkg::DEFAULT_DURATION;
            slot_qend[s]   = deadline_at(p.now_seconds, dur);
            slot_qvalid[s] = 1'b1;
            r.quarantine_started = 1'b1;
         end
         if (bump_burst(glob_start, glob_count, p.now_seconds, win, cfg_lock_thr)) begin
            dur = (cfg_lock_sec != 0) ? cfg_lock_sec : dbqg_pkg::DEFAULT_DURATION;
            lockdown_until = deadline_at(p.now_seconds, dur);
            r.lockdown_started = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic void add_req(dbqg_pkg::req_kind_type kind, int slot, bit idp,
                                   dbqg_pkg::outcome_type oc, dbqg_pkg::reason_type rc,
                                   logic [dbqg_pkg::TIME_W-1:0] t, bit typed,
                                   verdict_rec_type want);
      script_step_type st;
      st.kind                 = STEP_REQUEST;
      st.csr_index            = '0;
      st.csr_value            = '0;
      st.req.req_type         = kind;
      st.req.subject_index    = dbqg_pkg::IDX_W'(slot);
      st.req.id_present       = idp;
      st.req.outcome          = oc;
      st.req.reason_class     = rc;
      st.req.now_seconds      = t;
      st.typed                = typed;
      st.want                 = want;
      script.push_back(st);
   endfunction

   function automatic void add_csr(logic [dbqg_pkg::CSR_IDX_W-1:0] idx,
                                   logic [dbqg_pkg::CSR_DATA_W-1:0] v);
      script_step_type st;
      st.kind      = STEP_CSR;
      st.csr_index = idx;
      st.csr_value = v;
      st.req       = '0;
      st.typed     = 1'b0;
      st.want      = PASS_RESULT;
      script.push_back(st);
   endfunction

   // Offers one request and records its expected response once it is taken.
   // Valid stays high afterwards so back-to-back requests need no gap.
   task automatic send_req(dbqg_pkg::req_payload_type p, bit typed,
                           verdict_rec_type want);
      verdict_rec_type predicted;
      if (!steady && $urandom_range(99) < 10) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.req_type      <= p.req_type;
      req_ch.subject_index <= p.subject_index;
      req_ch.id_present    <= p.id_present;
      req_ch.outcome       <= p.outcome;
      req_ch.reason_class  <= p.reason_class;
      req_ch.now_seconds   <= p.now_seconds;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = guard_verdict(p);
      pending_verdicts.push_back(typed ? want : predicted);
   endtask

   task automatic drain_verdicts();
      req_ch.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [dbqg_pkg::CSR_IDX_W-1:0] idx,
                            logic [dbqg_pkg::CSR_DATA_W-1:0] v);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= v;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         dbqg_pkg::CSR_GUARD_ENABLED:      cfg_enabled  = v[0];
         dbqg_pkg::CSR_WINDOW_SECONDS:     cfg_window   = v[dbqg_pkg::COUNT_W-1:0];
         dbqg_pkg::CSR_DENY_THRESHOLD:     cfg_deny_thr = v[dbqg_pkg::COUNT_W-1:0];
         dbqg_pkg::CSR_QUARANTINE_SECONDS: cfg_quar_sec = v[dbqg_pkg::COUNT_W-1:0];
         dbqg_pkg::CSR_LOCKDOWN_THRESHOLD: cfg_lock_thr = v[dbqg_pkg::COUNT_W-1:0];
         dbqg_pkg::CSR_LOCKDOWN_SECONDS:   cfg_lock_sec = v[dbqg_pkg::COUNT_W-1:0];
         dbqg_pkg::CSR_DENYLIST_BITS:      cfg_denylist = v;
         default: ;
      endcase
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Response side: random back-pressure, or one long hold-off on request.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_ch.ready <= steady || ($urandom_range(99) >= 10);
         end
      end
   end

   always @(posedge clock) begin
      verdict_rec_type exp;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_verdicts.size() == 0) begin
            $error("response with no request outstanding");
            mismatch_count++;
         end else begin
            exp = pending_verdicts.pop_front();
            if (rsp_ch.allowed !== exp.allowed) begin
               $error("allowed expected %0d got %0d", exp.allowed, rsp_ch.allowed);
               mismatch_count++;
            end
            if (rsp_ch.verdict !== exp.verdict) begin
               $error("verdict expected %0d got %0d", exp.verdict, rsp_ch.verdict);
               mismatch_count++;
            end
            if (rsp_ch.retry_secs !== exp.retry) begin
               $error("retry_secs expected %0d got %0d", exp.retry,
                      rsp_ch.retry_secs);
               mismatch_count++;
            end
            if (rsp_ch.quarantine_started !== exp.quarantine_started) begin
               $error("quarantine_started expected %0d got %0d", exp.quarantine_started,
                      rsp_ch.quarantine_started);
               mismatch_count++;
            end
            if (rsp_ch.lockdown_started !== exp.lockdown_started) begin
               $error("lockdown_started expected %0d got %0d", exp.lockdown_started,
                      rsp_ch.lockdown_started);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: too long without any handshake on any channel ends the run.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("deny_burst_quarantine_guard test failed");
         $finish;
      end
   end

   initial begin
      script_step_type                 st;
      dbqg_pkg::req_payload_type       p;
      logic [dbqg_pkg::TIME_W-1:0]     now_t;
      logic [dbqg_pkg::CSR_DATA_W-1:0] cfg_next[7];
      logic [dbqg_pkg::CSR_DATA_W-1:0] sparse;
      int                              focus[4];
      int                              roll;
      verdict_rec_type                 want;

      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.req_type      <= dbqg_pkg::REQ_CHECK;
      req_ch.subject_index <= '0;
      req_ch.id_present    <= 1'b0;
      req_ch.outcome       <= dbqg_pkg::OUTCOME_ALLOW;
      req_ch.reason_class  <= dbqg_pkg::REASON_ORDINARY;
      req_ch.now_seconds   <= '0;
      csr_ch.valid         <= 1'b0;
      csr_ch.index         <= dbqg_pkg::CSR_GUARD_ENABLED;
      csr_ch.data          <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values, then outcomes that must never be counted.
      add_req(dbqg_pkg::REQ_CHECK, 0, 1, dbqg_pkg::OUTCOME_ALLOW,
              dbqg_pkg::REASON_ORDINARY, 32'd0, 1, PASS_RESULT);
      add_req(dbqg_pkg::REQ_CHECK, 63, 1, dbqg_pkg::OUTCOME_ALLOW,
              dbqg_pkg::REASON_ORDINARY, '1, 1, PASS_RESULT);
      add_req(dbqg_pkg::REQ_RECORD, 10, 1, dbqg_pkg::OUTCOME_ALLOW,
              dbqg_pkg::REASON_ORDINARY, 32'd5, 1, PASS_RESULT);
      add_req(dbqg_pkg::REQ_RECORD, 10, 1, dbqg_pkg::OUTCOME_OTHER,
              dbqg_pkg::REASON_ORDINARY, 32'd5, 1, PASS_RESULT);
      add_req(dbqg_pkg::REQ_RECORD, 10, 0, dbqg_pkg::OUTCOME_DENY,
              dbqg_pkg::REASON_ORDINARY, 32'd5, 1, PASS_RESULT);
      add_req(dbqg_pkg::REQ_RECORD, 10, 1, dbqg_pkg::OUTCOME_DENY,
              dbqg_pkg::REASON_QUARANTINED, 32'd5, 1, PASS_RESULT);
      add_req(dbqg_pkg::REQ_RECORD, 10, 1, dbqg_pkg::OUTCOME_ERROR,
              dbqg_pkg::REASON_LOCKDOWN, 32'd5, 1, PASS_RESULT);
      add_req(dbqg_pkg::REQ_RECORD, 10, 1, dbqg_pkg::OUTCOME_DENY,
              dbqg_pkg::REASON_DENYLIST, 32'd5, 1, PASS_RESULT);
      // Zero window and quarantine length fall back to their defaults.
      add_csr(dbqg_pkg::CSR_WINDOW_SECONDS, 64'd0);
      add_csr(dbqg_pkg::CSR_DENY_THRESHOLD, 64'd2);
      add_csr(dbqg_pkg::CSR_QUARANTINE_SECONDS, 64'd0);
      add_csr(dbqg_pkg::CSR_LOCKDOWN_THRESHOLD, 64'd3);
      add_csr(dbqg_pkg::CSR_LOCKDOWN_SECONDS, 64'd65535);
      add_csr(dbqg_pkg::CSR_DENYLIST_BITS, (64'd1 << 5) | (64'd1 << 63));
      add_csr(CSR_UNMAPPED, '1);
      want = '{1'b0, dbqg_pkg::VERDICT_FORBIDDEN, 16'd0, 1'b0, 1'b0};
      add_req(dbqg_pkg::REQ_CHECK, 5, 1, dbqg_pkg::OUTCOME_ALLOW,
              dbqg_pkg::REASON_ORDINARY, 32'd10, 1, want);
      add_req(dbqg_pkg::REQ_CHECK, 63, 0, dbqg_pkg::OUTCOME_OTHER,
              dbqg_pkg::REASON_DENYLIST, 32'd10, 1, want);
      add_req(dbqg_pkg::REQ_RECORD, 10, 1, dbqg_pkg::OUTCOME_DENY,
              dbqg_pkg::REASON_ORDINARY, 32'd10, 1, PASS_RESULT);
      add_req(dbqg_pkg::REQ_RECORD, 10, 1, dbqg_pkg::OUTCOME_ERROR,
              dbqg_pkg::REASON_ORDINARY, 32'd11, 1,
              '{1'b1, dbqg_pkg::VERDICT_ALLOW, 16'd0, 1'b1, 1'b0});
      add_req(dbqg_pkg::REQ_CHECK, 10, 1, dbqg_pkg::OUTCOME_ALLOW,
              dbqg_pkg::REASON_ORDINARY, 32'd12, 1,
              '{1'b0, dbqg_pkg::VERDICT_QUARANTINE, 16'd299, 1'b0, 1'b0});
      add_req(dbqg_pkg::REQ_RECORD, 20, 1, dbqg_pkg::OUTCOME_DENY,
              dbqg_pkg::REASON_ORDINARY, 32'd13, 1,
              '{1'b1, dbqg_pkg::VERDICT_ALLOW, 16'd0, 1'b0, 1'b1});
      add_req(dbqg_pkg::REQ_CHECK, 20, 1, dbqg_pkg::OUTCOME_ALLOW,
              dbqg_pkg::REASON_ORDINARY, 32'd13, 1,
              '{1'b0, dbqg_pkg::VERDICT_LOCKDOWN, 16'd65535, 1'b0, 1'b0});
      // The denylist wins over an active lockdown.
      add_req(dbqg_pkg::REQ_CHECK, 5, 1, dbqg_pkg::OUTCOME_ALLOW,
              dbqg_pkg::REASON_ORDINARY, 32'd13, 1, want);
      // Lockdown ends exactly at its deadline; the stale quarantine is cleared.
      add_req(dbqg_pkg::REQ_CHECK, 10, 1, dbqg_pkg::OUTCOME_ALLOW,
              dbqg_pkg::REASON_ORDINARY, 32'd65548, 1, PASS_RESULT);
      add_req(dbqg_pkg::REQ_CHECK, 10, 1, dbqg_pkg::OUTCOME_ALLOW,
              dbqg_pkg::REASON_ORDINARY, 32'd65548, 1, PASS_RESULT);
      add_csr(dbqg_pkg::CSR_GUARD_ENABLED, 64'd0);
      add_req(dbqg_pkg::REQ_CHECK, 5, 1, dbqg_pkg::OUTCOME_ALLOW,
              dbqg_pkg::REASON_ORDINARY, 32'd65548, 1, PASS_RESULT);
      add_req(dbqg_pkg::REQ_RECORD, 30, 1, dbqg_pkg::OUTCOME_DENY,
              dbqg_pkg::REASON_ORDINARY, 32'd65549, 1, PASS_RESULT);
      add_csr(dbqg_pkg::CSR_GUARD_ENABLED, 64'd1);
      // A quarantine deadline close to the top of the time range saturates.
      add_req(dbqg_pkg::REQ_RECORD, 40, 1, dbqg_pkg::OUTCOME_DENY,
              dbqg_pkg::REASON_ORDINARY, 32'hFFFF_FF00, 0, PASS_RESULT);
      add_req(dbqg_pkg::REQ_RECORD, 40, 1, dbqg_pkg::OUTCOME_ERROR,
              dbqg_pkg::REASON_ORDINARY, 32'hFFFF_FF01, 0, PASS_RESULT);
      add_req(dbqg_pkg::REQ_CHECK, 40, 1, dbqg_pkg::OUTCOME_ALLOW,
              dbqg_pkg::REASON_ORDINARY, 32'hFFFF_FFFE, 0, PASS_RESULT);
      add_req(dbqg_pkg::REQ_CHECK, 63, 1, dbqg_pkg::OUTCOME_ALLOW,
              dbqg_pkg::REASON_ORDINARY, '1, 1, want);

      foreach (script[i]) begin
         st = script[i];
         if (st.kind == STEP_CSR) begin
            drain_verdicts();
            write_csr(st.csr_index, st.csr_value);
         end else begin
            send_req(st.req, st.typed, st.want);
         end
      end

      // Time restarts low here, so the first windows see time step backwards.
      now_t = 32'd1000;
      for (int ph = 0; ph < PHASES; ph++) begin
         sparse = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
         case (ph)
            0: cfg_next = '{64'd1, 64'd60, 64'd20, 64'd300, 64'd0, 64'd300, sparse};
            1: cfg_next = '{64'd1, 64'd1, 64'd1, 64'd1, 64'd1, 64'd1, 64'd0};
            2: cfg_next = '{64'd1, 64'd65535, 64'd65535, 64'd65535, 64'd65535, 64'd65535,
                            sparse};
            3: cfg_next = '{64'd1, 64'd20, 64'd3, 64'd50, 64'd10, 64'd40, 64'd0};
            4: cfg_next = '{64'd0, 64'd30, 64'd2, 64'd100, 64'd2, 64'd100, sparse};
            5: cfg_next = '{64'd1, 64'd10, 64'd0, 64'd300, 64'd5, 64'd30, sparse};
            6: cfg_next = '{64'd1, 64'd60, 64'd4, 64'd200, 64'd0, 64'd300, '1};
            // Upper bits beyond each register's width must be dropped.
            7: cfg_next = '{{63'($urandom), 1'b1},
                            {48'({$urandom, $urandom}), 16'($urandom_range(1, 100))},
                            {48'({$urandom, $urandom}), 16'($urandom_range(0, 8))},
                            {48'({$urandom, $urandom}), 16'($urandom_range(1, 500))},
                            {48'({$urandom, $urandom}), 16'($urandom_range(0, 12))},
                            {48'({$urandom, $urandom}), 16'($urandom_range(1, 500))},
                            {$urandom, $urandom}};
            default: cfg_next = '{64'd1, 64'd0, 64'd2, 64'd0, 64'd3, 64'd0, sparse};
         endcase
         drain_verdicts();
         for (int r = 0; r < 7; r++) write_csr(dbqg_pkg::CSR_IDX_W'(r), cfg_next[r]);
         foreach (focus[k]) focus[k] = $urandom_range(SLOTS - 1);
         steady   = (ph == 5);
         hold_rsp = (ph == 3);
         for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
            roll = $urandom_range(99);
            if (roll < 2) now_t = now_t - $urandom_range(1, 100);
            else if (roll < 4) now_t = now_t + $urandom;
            else if (roll < 10) now_t = now_t + $urandom_range(0, 400);
            else now_t = now_t + $urandom_range(0, 3);
            p.now_seconds = now_t;
            // Mostly counted deny/error bursts and checks on a few hot slots.
            if ($urandom_range(99) < 70) begin
               p.req_type      = ($urandom_range(99) < 60) ? dbqg_pkg::REQ_RECORD
                                                           : dbqg_pkg::REQ_CHECK;
               p.subject_index = dbqg_pkg::IDX_W'(focus[$urandom_range(3)]);
               p.id_present    = 1'b1;
               p.outcome       = $urandom_range(1) ? dbqg_pkg::OUTCOME_DENY
                                                   : dbqg_pkg::OUTCOME_ERROR;
               p.reason_class  = dbqg_pkg::REASON_ORDINARY;
            end else begin
               p.req_type      = 1'($urandom_range(1));
               p.subject_index = dbqg_pkg::IDX_W'($urandom_range(SLOTS - 1));
               p.id_present    = 1'($urandom_range(1));
               p.outcome       = 2'($urandom_range(3));
               p.reason_class  = 2'($urandom_range(3));
            end
            send_req(p, 1'b0, PASS_RESULT);
         end
      end

      req_ch.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("deny_burst_quarantine_guard test passed");
      end else begin
         $display("deny_burst_quarantine_guard test failed");
      end
      $finish;
   end

endmodule
